/* rtl/sphere_mesh_index_generator_defines.svh */
// Assertion macros used by the sphere mesh index generator top level.
// Depends on nothing; users must have aclk and aresetn in scope.
`ifndef SPHERE_MESH_INDEX_GENERATOR_DEFINES_SVH
`define SPHERE_MESH_INDEX_GENERATOR_DEFINES_SVH

// Checked on every rising edge of aclk outside reset.
`define SMIG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define SMIG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* rtl/smig_pkg.sv */
// Package for the sphere mesh index generator: widths, codes and shared types.
// Depends on nothing; used by smig_group_gen and sphere_mesh_index_generator.
`default_nettype none

package smig_pkg;

    localparam int unsigned MAX_POINTS = 1024;
    localparam int unsigned MIN_POINTS = 4;

    localparam int unsigned P_W      = 11;
    localparam int unsigned RING_W   = 9;
    localparam int unsigned COL_W    = 10;
    localparam int unsigned CORNER_W = 20;
    localparam int unsigned IDX_W    = 32;
    localparam int unsigned GROUP_SIZE = 6;
    localparam int unsigned SLOT_W   = 3;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(GROUP_SIZE - 1);

    // Mesh phases.
    localparam logic [1:0] PH_BANDS = 2'd0;
    localparam logic [1:0] PH_CAPS  = 2'd1;
    localparam logic [1:0] PH_DONE  = 2'd2;

    // Register selects, taken from paddr bit 2.
    localparam logic REG_POINTS = 1'b0;
    localparam logic REG_BASE   = 1'b1;

    // Working configuration, derived when points_per_circle is written (base when the base register is).
    typedef struct packed {
        logic [P_W-1:0]      p;      // clamped points per circle
        logic [RING_W-1:0]   r_m1;   // rings minus one
        logic [COL_W-1:0]    p_m1;   // points minus one
        logic [CORNER_W-1:0] top;    // p * (rings - 1)
        logic [CORNER_W-1:0] rp1;    // rings * p + 1
        logic [IDX_W-1:0]    base;   // vertex base offset
    } cfg_t;

    typedef struct packed {
        logic [GROUP_SIZE-1:0][IDX_W-1:0] idx;
        logic                             done;
    } group_t;

endpackage

`default_nettype wire

/* rtl/smig_group_gen.sv */
// Mesh walk state and the six indices of one group, computed in a single pass.
// Depends on smig_pkg.
`default_nettype none

module smig_group_gen (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_accept,
    input  wire logic            item_restart,
    input  wire smig_pkg::cfg_t  cfg,
    input  wire logic            group_take,
    output logic                 group_valid,
    output smig_pkg::group_t     group
);

    logic [1:0]                          phase_reg, phase_next;
    logic [smig_pkg::RING_W-1:0]         ring_reg, ring_next;
    logic [smig_pkg::COL_W-1:0]          col_reg, col_next;
    logic [smig_pkg::CORNER_W-1:0]       corner_reg, corner_next;
    logic                                gvalid_reg, gvalid_next;
    smig_pkg::group_t                    group_reg, group_next;

    logic [1:0]                          ph;
    logic [smig_pkg::RING_W-1:0]         rc, ring_inc;
    logic [smig_pkg::COL_W-1:0]          cc;
    logic [smig_pkg::CORNER_W-1:0]       ci, ring_prod;
    logic [smig_pkg::COL_W:0]            col_inc;
    logic                                wrap;
    logic [smig_pkg::CORNER_W:0]         z1, z2, z3, z4, cap_lo;
    logic                                produce;

    assign ring_inc  = rc + smig_pkg::RING_W'(1);
    assign ring_prod = {{(smig_pkg::CORNER_W - smig_pkg::RING_W){1'b0}}, ring_inc}
                     * {{(smig_pkg::CORNER_W - smig_pkg::P_W){1'b0}}, cfg.p};

    always_comb begin
        // A restart takes effect before the phase checks of the same item.
        ph = item_restart ? smig_pkg::PH_BANDS : phase_reg;
        rc = item_restart ? '0 : ring_reg;
        cc = item_restart ? '0 : col_reg;
        ci = item_restart ? smig_pkg::CORNER_W'(1) : corner_reg;

        if (ph == smig_pkg::PH_BANDS && rc >= cfg.r_m1) begin
            ph = smig_pkg::PH_CAPS;
            cc = '0;
        end
        if (ph == smig_pkg::PH_CAPS && cc >= cfg.p_m1) begin
            ph = smig_pkg::PH_DONE;
        end

        col_inc = {1'b0, cc} + (smig_pkg::COL_W + 1)'(1);
        wrap    = col_inc >= {1'b0, cfg.p_m1};

        z1 = {1'b0, ci};
        z2 = z1 + (smig_pkg::CORNER_W + 1)'(1);
        z3 = z1 + (smig_pkg::CORNER_W + 1)'(cfg.p);
        z4 = z2 + (smig_pkg::CORNER_W + 1)'(cfg.p);
        cap_lo = {1'b0, cfg.top} + (smig_pkg::CORNER_W + 1)'(col_inc);

        phase_next  = ph;
        ring_next   = rc;
        col_next    = cc;
        corner_next = ci;
        group_next  = group_reg;
        produce     = 1'b0;

        unique case (ph)
            smig_pkg::PH_BANDS: begin
                produce = 1'b1;
                group_next.idx[0] = smig_pkg::IDX_W'(z1);
                group_next.idx[1] = smig_pkg::IDX_W'(z3);
                group_next.idx[2] = smig_pkg::IDX_W'(z4);
                group_next.idx[3] = smig_pkg::IDX_W'(z1);
                group_next.idx[4] = smig_pkg::IDX_W'(z4);
                group_next.idx[5] = smig_pkg::IDX_W'(z2);
                group_next.done   = 1'b0;
                if (wrap) begin
                    col_next    = '0;
                    ring_next   = ring_inc;
                    corner_next = ring_prod + smig_pkg::CORNER_W'(1);
                end else begin
                    col_next    = col_inc[smig_pkg::COL_W-1:0];
                    corner_next = ci + smig_pkg::CORNER_W'(1);
                end
            end
            smig_pkg::PH_CAPS: begin
                produce = 1'b1;
                group_next.idx[0] = smig_pkg::IDX_W'(col_inc);
                group_next.idx[1] = smig_pkg::IDX_W'(col_inc) + smig_pkg::IDX_W'(1);
                group_next.idx[2] = cfg.base;
                group_next.idx[3] = smig_pkg::IDX_W'(cap_lo) + smig_pkg::IDX_W'(1);
                group_next.idx[4] = smig_pkg::IDX_W'(cap_lo);
                group_next.idx[5] = cfg.base + smig_pkg::IDX_W'(cfg.rp1);
                group_next.done   = wrap;
                col_next          = col_inc[smig_pkg::COL_W-1:0];
                if (wrap) begin
                    phase_next = smig_pkg::PH_DONE;
                end
            end
            default: begin
                produce = 1'b0;
            end
        endcase

        gvalid_next = gvalid_reg && !group_take;
        if (item_accept && produce) begin
            gvalid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= smig_pkg::PH_BANDS;
            ring_reg   <= '0;
            col_reg    <= '0;
            corner_reg <= smig_pkg::CORNER_W'(1);
            gvalid_reg <= 1'b0;
        end else begin
            gvalid_reg <= gvalid_next;
            if (item_accept) begin
                phase_reg  <= phase_next;
                ring_reg   <= ring_next;
                col_reg    <= col_next;
                corner_reg <= corner_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_accept && produce) begin
            group_reg <= group_next;
        end
    end

    assign group_valid = gvalid_reg;
    assign group       = group_reg;

endmodule

`default_nettype wire

/* rtl/sphere_mesh_index_generator.sv */
// Latency: a group passes through the group register and then the output word stage before its first index leaves.
// Throughput: one index per cycle when the result side keeps up; the single output word
// per cycle sets this. A request after the mesh is finished gives no indices.
// Reset: synchronous, active low; the walk restarts at the first band group and the
// registers return to four points per circle and a zero vertex base.
`default_nettype none
`include "sphere_mesh_index_generator_defines.svh"

module sphere_mesh_index_generator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Request channel.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    // Index channel.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] index_value
    output logic             m_tlast,   // group_last
    output logic [0:0]       m_tuser,   // [0] mesh_done
    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [smig_pkg::P_W-1:0]   ppc_reg;
    smig_pkg::cfg_t             cfg_reg;
    logic                       cfg_write;

    logic [smig_pkg::P_W-1:0]       p_raw, p_clamp;
    logic [smig_pkg::RING_W-1:0]    r_new, r_m1_new;
    logic [smig_pkg::CORNER_W-1:0]  top_new;

    logic                       gen_valid;
    smig_pkg::group_t           gen_group;
    logic                       in_accept;

    logic                       o_valid_reg;
    logic [smig_pkg::SLOT_W-1:0] o_cnt_reg;
    logic [smig_pkg::GROUP_SIZE-1:0][smig_pkg::IDX_W-1:0] o_vals_reg;
    logic                       o_done_reg;
    logic                       o_last, o_free, o_load, o_take;

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        p_raw = pwdata[smig_pkg::P_W-1:0];
        if (p_raw < smig_pkg::P_W'(smig_pkg::MIN_POINTS)) begin
            p_clamp = smig_pkg::P_W'(smig_pkg::MIN_POINTS);
        end else if (p_raw > smig_pkg::P_W'(smig_pkg::MAX_POINTS)) begin
            p_clamp = smig_pkg::P_W'(smig_pkg::MAX_POINTS);
        end else begin
            p_clamp = p_raw;
        end
        r_new    = smig_pkg::RING_W'(p_clamp >> 1) - smig_pkg::RING_W'(1);
        r_m1_new = r_new - smig_pkg::RING_W'(1);
        top_new  = {{(smig_pkg::CORNER_W - smig_pkg::RING_W){1'b0}}, r_m1_new}
                 * {{(smig_pkg::CORNER_W - smig_pkg::P_W){1'b0}}, p_clamp};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppc_reg      <= smig_pkg::P_W'(smig_pkg::MIN_POINTS);
            cfg_reg.p    <= smig_pkg::P_W'(smig_pkg::MIN_POINTS);
            cfg_reg.r_m1 <= '0;
            cfg_reg.p_m1 <= smig_pkg::COL_W'(smig_pkg::MIN_POINTS - 1);
            cfg_reg.top  <= '0;
            cfg_reg.rp1  <= smig_pkg::CORNER_W'(smig_pkg::MIN_POINTS + 1);
            cfg_reg.base <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                smig_pkg::REG_POINTS: begin
                    ppc_reg      <= p_raw;
                    cfg_reg.p    <= p_clamp;
                    cfg_reg.r_m1 <= r_m1_new;
                    cfg_reg.p_m1 <= smig_pkg::COL_W'(p_clamp - smig_pkg::P_W'(1));
                    cfg_reg.top  <= top_new;
                    cfg_reg.rp1  <= top_new + smig_pkg::CORNER_W'(p_clamp)
                                  + smig_pkg::CORNER_W'(1);
                end
                smig_pkg::REG_BASE: begin
                    cfg_reg.base <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            smig_pkg::REG_POINTS: prdata = {{(32 - smig_pkg::P_W){1'b0}}, ppc_reg};
            smig_pkg::REG_BASE:   prdata = cfg_reg.base;
            default:              prdata = '0;
        endcase
    end

    // Output word stage: holds one group and hands it out one index per cycle while m_tready is high.
    assign o_last = (o_cnt_reg == smig_pkg::LAST_SLOT);
    assign o_take = o_valid_reg && m_tready;
    assign o_free = !o_valid_reg || (m_tready && o_last);
    assign o_load = o_free && gen_valid;

    // A new request is taken whenever the group register is empty or moving on.
    assign s_tready  = !gen_valid || o_free;
    assign in_accept = s_tvalid && s_tready;

    smig_group_gen u_group_gen (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_accept  (in_accept),
        .item_restart (s_tdata[0]),
        .cfg          (cfg_reg),
        .group_take   (o_load),
        .group_valid  (gen_valid),
        .group        (gen_group)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            o_cnt_reg   <= '0;
        end else if (o_load) begin
            o_valid_reg <= 1'b1;
            o_cnt_reg   <= '0;
        end else if (o_take) begin
            o_valid_reg <= !o_last;
            o_cnt_reg   <= o_cnt_reg + smig_pkg::SLOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (o_load) begin
            o_vals_reg <= gen_group.idx;
            o_done_reg <= gen_group.done;
        end else if (o_take) begin
            o_vals_reg <= o_vals_reg >> smig_pkg::IDX_W;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = o_vals_reg[0];
    assign m_tlast  = o_last;
    assign m_tuser  = o_done_reg && o_last;

    `SMIG_ASSERT(a_ready_when_group_empty, !gen_valid |-> s_tready, "request refused with empty group register")
    `SMIG_ASSERT(a_done_only_on_last, (m_tvalid && m_tuser[0]) |-> m_tlast, "mesh_done away from the last index")
    `SMIG_ASSERT(a_group_loads_at_slot0, (gen_valid && o_free) |=> (m_tvalid && o_cnt_reg == '0), "pending group not loaded")
    `SMIG_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> (!m_tvalid && !gen_valid), "reset left a word pending")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for sphere_mesh_index_generator: requests go in on the s_ stream,
// index words are checked against a predictor of the band and pole-cap walk held in a
// scoreboard class. Depends on smig_pkg and the RTL top level only.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TARGET_REQUESTS = 230;

    typedef struct packed {
        logic [smig_pkg::IDX_W-1:0] index_value;
        logic                       group_last;
        logic                       mesh_done;
    } index_word_t;

    // Mirrors the register file and the mesh walk, and queues the index words due.
    class mesh_scoreboard;
        logic [smig_pkg::P_W-1:0]   points_reg;
        logic [smig_pkg::IDX_W-1:0] base_reg;
        logic [1:0]       walk_phase;
        logic [31:0]      ring_cnt;
        logic [31:0]      col_cnt;
        logic [31:0]      corner;
        index_word_t      expected_q[$];
        int               mismatches;
        int               words_checked;
        int               meshes_finished;

        function new();
            points_reg      = smig_pkg::P_W'(smig_pkg::MIN_POINTS);
            base_reg        = '0;
            mismatches      = 0;
            words_checked   = 0;
            meshes_finished = 0;
            restart_walk();
        endfunction

        function void restart_walk();
            walk_phase = smig_pkg::PH_BANDS;
            ring_cnt   = 0;
            col_cnt    = 0;
            corner     = 1;
        endfunction

        function void write_reg(logic sel, logic [31:0] value);
            if (sel == smig_pkg::REG_POINTS) begin
                points_reg = value[smig_pkg::P_W-1:0];
            end else begin
                base_reg = value;
            end
        endfunction

        function logic [31:0] clamped_points();
            logic [31:0] p;
            p = 32'(points_reg);
            if (p < smig_pkg::MIN_POINTS) p = smig_pkg::MIN_POINTS;
            if (p > smig_pkg::MAX_POINTS) p = smig_pkg::MAX_POINTS;
            return p;
        endfunction

        // Number of groups in a whole mesh at the current setting.
        function int mesh_groups();
            logic [31:0] p;
            p = clamped_points();
            return int'((p / 2 - 1) * (p - 1));
        endfunction

        // Advances the walk by one request; returns how many index words it queued.
        function int note_request(logic restart);
            logic [31:0]                p;
            logic [31:0]                r;
            logic [31:0]                top;
            logic [31:0]                ix;
            logic [smig_pkg::IDX_W-1:0] v [smig_pkg::GROUP_SIZE];
            logic                       finished;
            index_word_t                w;

            if (restart) restart_walk();
            p        = clamped_points();
            r        = p / 2 - 1;
            finished = 1'b0;

            if (walk_phase == smig_pkg::PH_BANDS && ring_cnt >= r - 1) begin
                walk_phase = smig_pkg::PH_CAPS;
                col_cnt    = 0;
            end
            if (walk_phase == smig_pkg::PH_CAPS && col_cnt >= p - 1)
                walk_phase = smig_pkg::PH_DONE;
            if (walk_phase != smig_pkg::PH_BANDS && walk_phase != smig_pkg::PH_CAPS)
                return 0;

            if (walk_phase == smig_pkg::PH_BANDS) begin
                v[0] = corner;
                v[1] = corner + p;
                v[2] = corner + 1 + p;
                v[3] = corner;
                v[4] = corner + 1 + p;
                v[5] = corner + 1;
                col_cnt = col_cnt + 1;
                corner  = corner + 1;
                if (col_cnt >= p - 1) begin
                    col_cnt  = 0;
                    ring_cnt = ring_cnt + 1;
                    corner   = ring_cnt * p + 1;
                end
            end else begin
                ix   = col_cnt + 1;
                top  = p * (r - 1);
                v[0] = ix;
                v[1] = ix + 1;
                v[2] = base_reg;
                v[3] = top + ix + 1;
                v[4] = top + ix;
                v[5] = base_reg + r * p + 1;
                col_cnt = col_cnt + 1;
                if (col_cnt >= p - 1) begin
                    finished   = 1'b1;
                    walk_phase = smig_pkg::PH_DONE;
                end
            end

            for (int k = 0; k < smig_pkg::GROUP_SIZE; k++) begin
                w.index_value = v[k];
                w.group_last  = (k == smig_pkg::GROUP_SIZE - 1);
                w.mesh_done   = (k == smig_pkg::GROUP_SIZE - 1) && finished;
                expected_q.push_back(w);
            end
            return smig_pkg::GROUP_SIZE;
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_index(logic [smig_pkg::IDX_W-1:0] index_value, logic group_last,
                         logic mesh_done);
            index_word_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("index word %0h arrived with nothing outstanding",
                                 index_value));
                return;
            end
            e = expected_q.pop_front();
            words_checked++;
            if (index_value !== e.index_value)
                report($sformatf("index_value expected %0h, got %0h",
                                 e.index_value, index_value));
            if (group_last !== e.group_last)
                report($sformatf("group_last expected %0b, got %0b", e.group_last, group_last));
            if (mesh_done !== e.mesh_done)
                report($sformatf("mesh_done expected %0b, got %0b", e.mesh_done, mesh_done));
            else if (mesh_done === 1'b1)
                meshes_finished++;
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;     // [0] restart, [7:1] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;     // [31:0] index_value
    logic        m_tlast;
    logic [0:0]  m_tuser;     // [0] mesh_done
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mesh_scoreboard sb = new();

    bit sender_idle   = 1'b1;
    bit receiver_idle = 1'b1;
    int requests_counted = 0;
    int reg_writes       = 0;

    sphere_mesh_index_generator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Result side: stall a random number of cycles before taking each word.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            stall = receiver_idle ? $urandom_range(0, 7) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_index(m_tdata, m_tlast, m_tuser[0]);
    end

    // Ends the run if no word moves on any port for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired with %0d index words outstanding", sb.expected_q.size());
        $display("TEST FAILED");
        $finish;
    end

    task apb_write(logic sel, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(sel, value);
        reg_writes++;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Holds the request side until every queued index word has been taken.
    task drain();
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    // As drain, then leaves time for a request that gives no words to finish.
    task settle();
        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // The gap after each word is drawn here, so tvalid only drops when a gap follows.
    task send_request(logic restart);
        int gap;
        s_tvalid = 1'b1;
        s_tdata  = {7'd0, restart};
        do @(posedge aclk); while (!s_tready);
        if (sb.note_request(restart) > 0) requests_counted++;
        @(negedge aclk);
        gap = sender_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task send_run(logic first_restart, int count, int noise_pct);
        logic restart;
        for (int i = 0; i < count; i++) begin
            restart = (i == 0) ? first_restart : ($urandom_range(0, 99) < noise_pct);
            if ($urandom_range(0, 29) == 0) drain();
            send_request(restart);
        end
    endtask

    initial begin
        int          choice;
        int          count;
        logic [31:0] p_val;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset setting has a single ring: three cap groups, then a finished mesh
        // that ignores a plain request, then a restart.
        send_run(1'b0, 4, 0);
        send_run(1'b1, 1, 0);

        // Points of zero clamp up to four; the pole base wraps at the top of the range.
        settle();
        apb_write(smig_pkg::REG_BASE, 32'hFFFF_FFFF);
        apb_write(smig_pkg::REG_POINTS, 32'd0);
        send_run(1'b1, 3, 0);

        // Two rings: one band of five quads, then five cap groups.
        settle();
        apb_write(smig_pkg::REG_BASE, 32'h0000_1000);
        apb_write(smig_pkg::REG_POINTS, 32'd6);
        send_run(1'b1, 10, 0);

        // All-ones points clamp down to the maximum; only the first few band groups.
        settle();
        apb_write(smig_pkg::REG_BASE, 32'hFFFF_FFF0);
        apb_write(smig_pkg::REG_POINTS, 32'd2047);
        send_run(1'b1, 2, 0);

        // Enter the caps with four points, widen the circle mid-mesh, then shrink it
        // again so the column counter already sits past the new bound.
        settle();
        apb_write(smig_pkg::REG_POINTS, 32'd4);
        send_run(1'b1, 1, 0);
        settle();
        apb_write(smig_pkg::REG_POINTS, 32'd1024);
        send_run(1'b0, 3, 0);
        settle();
        apb_write(smig_pkg::REG_POINTS, 32'd4);
        send_run(1'b0, 1, 0);

        // Random part: mostly whole meshes with the odd stray restart.
        while (requests_counted < TARGET_REQUESTS) begin
            settle();
            sender_idle   = ($urandom_range(0, 3) != 0);
            receiver_idle = ($urandom_range(0, 3) != 0);
            choice = $urandom_range(0, 9);
            if (choice == 0)
                p_val = $urandom_range(0, 3);
            else if (choice == 1)
                p_val = $urandom_range(1024, 2047);
            else
                p_val = $urandom_range(4, 14);
            // Now and then keep the old circle size so a walk can carry on across phases.
            if ($urandom_range(0, 4) != 0) apb_write(smig_pkg::REG_POINTS, p_val);
            case ($urandom_range(0, 3))
                0: apb_write(smig_pkg::REG_BASE, 32'h0000_0000);
                1: apb_write(smig_pkg::REG_BASE, 32'hFFFF_FFFF);
                2: apb_write(smig_pkg::REG_BASE, $urandom);
                default: ;
            endcase
            if (sb.clamped_points() > 16)
                count = $urandom_range(1, 4);
            else
                count = sb.mesh_groups() + $urandom_range(0, 2);
            // The last run is cut short so the total stays near the target.
            if (count > TARGET_REQUESTS - requests_counted)
                count = TARGET_REQUESTS - requests_counted;
            send_run($urandom_range(0, 9) != 0, count, 4);
        end

        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d producing requests and checked %0d index words",
                 requests_counted, sb.words_checked);
        $display("over %0d register writes; %0d meshes were walked to their final index.",
                 reg_writes, sb.meshes_finished);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
